/* hdl/idfe_pkg.sv */
`default_nettype none

package idfe_pkg;

  // Field widths
  localparam int TIME_W      = 12;
  localparam int ADDR_W      = 16;
  localparam int EXTRA_W     = 7;
  localparam int CMD_W       = 8;
  localparam int ELAPSED_W   = 18;
  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Frame layout: header, sixteen symbols, trailer
  localparam int PAIR_COUNT = 18;
  localparam int LAST_PAIR  = PAIR_COUNT - 1;
  localparam int PAIR_CNT_W = $clog2(PAIR_COUNT);

  // Defaults for the top-level parameters
  localparam logic [TIME_W-1:0] MARK_US_DEFAULT     = 12'd164;
  localparam int                QUEUE_DEPTH_DEFAULT = 2;

  // Register reset values
  localparam logic [TIME_W-1:0] HEADER_MARK_RST  = 12'd412;
  localparam logic [TIME_W-1:0] HEADER_SPACE_RST = 12'd276;
  localparam logic [TIME_W-1:0] SPACE_ZERO_RST   = 12'd276;
  localparam logic [TIME_W-1:0] SPACE_ONE_RST    = 12'd445;
  localparam logic [TIME_W-1:0] SPACE_TWO_RST    = 12'd614;
  localparam logic [TIME_W-1:0] SPACE_THREE_RST  = 12'd783;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA        = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARK  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SPACE = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_ZERO   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_ONE    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_TWO    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_THREE  = 4'd7;

  // Timing registers seen by the sequencer
  typedef struct packed {
    logic [TIME_W-1:0] header_mark;
    logic [TIME_W-1:0] header_space;
    logic [TIME_W-1:0] space_zero;
    logic [TIME_W-1:0] space_one;
    logic [TIME_W-1:0] space_two;
    logic [TIME_W-1:0] space_three;
  } timing_t;

endpackage

`default_nettype wire

/* hdl/idfe_front.sv */
`default_nettype none

module idfe_front
  import idfe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       command_code,
  input  wire logic                   ends_keypress,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output logic [WORD_W-1:0]           push_data,
  output timing_t                     timing
);

  logic [ADDR_W-1:0]  address_word;
  logic [EXTRA_W-1:0] extra_bits;
  logic               toggle_bit;
  logic               accept;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      address_word        <= '0;
      extra_bits          <= '0;
      timing.header_mark  <= HEADER_MARK_RST;
      timing.header_space <= HEADER_SPACE_RST;
      timing.space_zero   <= SPACE_ZERO_RST;
      timing.space_one    <= SPACE_ONE_RST;
      timing.space_two    <= SPACE_TWO_RST;
      timing.space_three  <= SPACE_THREE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADDRESS:      address_word        <= cfg_data[ADDR_W-1:0];
        REG_EXTRA:        extra_bits          <= cfg_data[EXTRA_W-1:0];
        REG_HEADER_MARK:  timing.header_mark  <= cfg_data[TIME_W-1:0];
        REG_HEADER_SPACE: timing.header_space <= cfg_data[TIME_W-1:0];
        REG_SPACE_ZERO:   timing.space_zero   <= cfg_data[TIME_W-1:0];
        REG_SPACE_ONE:    timing.space_one    <= cfg_data[TIME_W-1:0];
        REG_SPACE_TWO:    timing.space_two    <= cfg_data[TIME_W-1:0];
        REG_SPACE_THREE:  timing.space_three  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Pass requests straight into the queue
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Assemble the symbol word; the frame carries the toggle as it stands now
  assign push_data = {address_word, toggle_bit, extra_bits, command_code};

  // Flip the toggle once a key-press frame has been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_bit <= 1'b0;
    end else if (accept && ends_keypress) begin
      toggle_bit <= ~toggle_bit;
    end
  end

endmodule

`default_nettype wire

/* hdl/idfe_queue.sv */
`default_nettype none

module idfe_queue
  import idfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [WORD_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [WORD_W-1:0]      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/idfe_back.sv */
`default_nettype none

module idfe_back
  import idfe_pkg::*;
#(
  parameter logic [TIME_W-1:0] MARK_US = MARK_US_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire timing_t           timing,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire logic [WORD_W-1:0] pop_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [TIME_W-1:0]      mark_us,
  output logic [TIME_W-1:0]      space_us,
  output logic                   is_last,
  output logic [ELAPSED_W-1:0]   elapsed_us
);

  localparam logic [1:0] SYM_ZERO  = 2'd0;
  localparam logic [1:0] SYM_ONE   = 2'd1;
  localparam logic [1:0] SYM_TWO   = 2'd2;
  localparam logic [1:0] SYM_THREE = 2'd3;

  logic                  busy;
  logic [PAIR_CNT_W-1:0] pair_cnt;
  logic [WORD_W-1:0]     sym_word;
  logic                  advance;
  logic                  trailer;
  logic [TIME_W-1:0]     sym_space;
  logic [TIME_W-1:0]     mark_sel;
  logic [TIME_W-1:0]     space_sel;
  logic [ELAPSED_W-1:0]  base;
  logic [ELAPSED_W:0]    sum;
  logic [ELAPSED_W-1:0]  elapsed_next;

  // Move on whenever the output register is free or being emptied
  assign advance   = !out_valid || out_ready;
  assign pop_ready = advance && !busy;
  assign trailer   = (pair_cnt == PAIR_CNT_W'(LAST_PAIR));

  // Map the top symbol to its space length
  always_comb begin
    case (sym_word[WORD_W-1 -: 2])
      SYM_ZERO:  sym_space = timing.space_zero;
      SYM_ONE:   sym_space = timing.space_one;
      SYM_TWO:   sym_space = timing.space_two;
      SYM_THREE: sym_space = timing.space_three;
      default:   sym_space = timing.space_zero;
    endcase
  end

  // Choose the pair: header when starting a frame, symbol or trailer otherwise
  always_comb begin
    if (busy) begin
      mark_sel  = MARK_US;
      space_sel = trailer ? '0 : sym_space;
      base      = elapsed_us;
    end else begin
      mark_sel  = timing.header_mark;
      space_sel = timing.header_space;
      base      = '0;
    end
    sum          = {1'b0, base} + (ELAPSED_W+1)'(mark_sel) + (ELAPSED_W+1)'(space_sel);
    elapsed_next = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
  end

  // Sequence the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pair_cnt  <= '0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        pair_cnt  <= pair_cnt + 1'b1;
        if (trailer) begin
          busy <= 1'b0;
        end
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        busy      <= 1'b1;
        pair_cnt  <= PAIR_CNT_W'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output pair and shift the symbol word
  always_ff @(posedge clk) begin
    if (advance && (busy || pop_valid)) begin
      mark_us    <= mark_sel;
      space_us   <= space_sel;
      is_last    <= busy && trailer;
      elapsed_us <= elapsed_next;
      sym_word   <= busy ? (sym_word << 2) : pop_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/ir_dibit_frame_encoder.sv */
// Infrared dibit frame encoder.
// Input channel (in_valid/in_ready) takes one frame request: command_code and
// ends_keypress. Output channel (out_valid/out_ready) gives 18 words per
// frame: the header pair, sixteen two-bit symbol pairs MSB first (address,
// toggle with extra bits, command), then the trailer with is_last set and a
// zero space. elapsed_us carries the running frame length, saturating.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes the
// address, extra bits and timing registers by index; other indexes are
// ignored. Write it only while no frame is in flight.
// A request that is taken passes through the request queue before its header word is loaded into the output register.
// The pair sequencer walks one pair per cycle, giving one word per cycle and
// frames back to back, while out_ready stays high and requests are queued.
// A small request queue sits between the front and the sequencer, so
// requests are taken while a frame is still being sent.
// Reset: registers return to their defaults, the toggle clears, queue and
// sequencer empty. When out_ready is low the current word holds and the
// sequencer waits; in_ready falls once the queue fills.
`default_nettype none

module ir_dibit_frame_encoder
  import idfe_pkg::*;
#(
  parameter logic [TIME_W-1:0] MARK_US     = MARK_US_DEFAULT,
  parameter int                QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       command_code,
  input  wire logic                   ends_keypress,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [TIME_W-1:0]           mark_us,
  output logic [TIME_W-1:0]           space_us,
  output logic                        is_last,
  output logic [ELAPSED_W-1:0]        elapsed_us
);

  logic              push_valid;
  logic              push_ready;
  logic [WORD_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [WORD_W-1:0] pop_data;
  timing_t           timing;

  idfe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command_code (command_code),
    .ends_keypress(ends_keypress),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data),
    .timing       (timing)
  );

  idfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  idfe_back #(
    .MARK_US(MARK_US)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .timing    (timing),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mark_us   (mark_us),
    .space_us  (space_us),
    .is_last   (is_last),
    .elapsed_us(elapsed_us)
  );

endmodule

`default_nettype wire

/* hdl/idfe_checker.sv */
`default_nettype none

module idfe_checker
  import idfe_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [TIME_W-1:0]    mark_us,
  input wire logic [TIME_W-1:0]    space_us,
  input wire logic                 is_last,
  input wire logic [ELAPSED_W-1:0] elapsed_us
);

  // Output is empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // Hold a stalled word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mark_us) && $stable(space_us)
      && $stable(is_last) && $stable(elapsed_us))
    else $error("stalled output word changed");

  // Trailer carries no space
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_last |-> space_us == '0)
    else $error("trailer with non-zero space");

  // Within a frame the next pair follows at once
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !is_last |=> out_valid)
    else $error("gap inside a frame");

  // Running length covers the current pair
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, elapsed_us} >= ({7'd0, mark_us} + {7'd0, space_us}))
    else $error("elapsed length below current pair");

endmodule

bind ir_dibit_frame_encoder idfe_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .mark_us   (mark_us),
  .space_us  (space_us),
  .is_last   (is_last),
  .elapsed_us(elapsed_us)
);

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idfe_pkg::*;

  localparam int SEND_PAIRS    = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 50;
  localparam int SETTLE_CYCLES = 20;

  // Indexes that no register answers to
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_LOW = REG_SPACE_THREE + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_TOP = '1;

  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [TIME_W-1:0]    mark;
    logic [TIME_W-1:0]    space;
    logic                 last;
    logic [ELAPSED_W-1:0] elapsed;
  } pulse_pair_t;

  // Frame predictor with its own register copy and toggle
  class frame_scoreboard;
    logic [ADDR_W-1:0]  address;
    logic [EXTRA_W-1:0] extra;
    logic [TIME_W-1:0]  hdr_mark;
    logic [TIME_W-1:0]  hdr_space;
    logic [TIME_W-1:0]  sym_space [4];
    logic               toggle;
    pulse_pair_t        pending [$];
    int unsigned        mismatches;

    function new();
      address      = '0;
      extra        = '0;
      hdr_mark     = HEADER_MARK_RST;
      hdr_space    = HEADER_SPACE_RST;
      sym_space[0] = SPACE_ZERO_RST;
      sym_space[1] = SPACE_ONE_RST;
      sym_space[2] = SPACE_TWO_RST;
      sym_space[3] = SPACE_THREE_RST;
      toggle       = 1'b0;
      mismatches   = 0;
    endfunction

    // Keep only the low bits each register holds; ignore unknown indexes
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ADDRESS:      address      = data[ADDR_W-1:0];
        REG_EXTRA:        extra        = data[EXTRA_W-1:0];
        REG_HEADER_MARK:  hdr_mark     = data[TIME_W-1:0];
        REG_HEADER_SPACE: hdr_space    = data[TIME_W-1:0];
        REG_SPACE_ZERO:   sym_space[0] = data[TIME_W-1:0];
        REG_SPACE_ONE:    sym_space[1] = data[TIME_W-1:0];
        REG_SPACE_TWO:    sym_space[2] = data[TIME_W-1:0];
        REG_SPACE_THREE:  sym_space[3] = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_pair(logic [TIME_W-1:0] mark, logic [TIME_W-1:0] space, logic last,
                            inout int unsigned total);
      pulse_pair_t p;
      total = total + mark + space;
      if (total > ELAPSED_MAX) total = ELAPSED_MAX;
      p.mark    = mark;
      p.space   = space;
      p.last    = last;
      p.elapsed = total[ELAPSED_W-1:0];
      pending.push_back(p);
    endfunction

    // Build the header, sixteen dibits MSB first and the trailer
    function void note_request(logic [CMD_W-1:0] cmd, logic ends);
      logic [WORD_W-1:0] symbols;
      int unsigned       total;
      int                k;
      total   = 0;
      symbols = {address, toggle, extra, cmd};
      push_pair(hdr_mark, hdr_space, 1'b0, total);
      for (k = SEND_PAIRS - 1; k >= 0; k--)
        push_pair(MARK_US_DEFAULT, sym_space[symbols[2*k +: 2]], 1'b0, total);
      push_pair(MARK_US_DEFAULT, '0, 1'b1, total);
      // The current frame carries the old toggle
      if (ends) toggle = ~toggle;
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_word(logic [TIME_W-1:0] mark, logic [TIME_W-1:0] space, logic last,
                    logic [ELAPSED_W-1:0] elapsed);
      pulse_pair_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending, mark %0d space %0d",
                                  mark, space));
        return;
      end
      want = pending.pop_front();
      if (mark !== want.mark)
        report_mismatch($sformatf("mark_us %0d, want %0d", mark, want.mark));
      if (space !== want.space)
        report_mismatch($sformatf("space_us %0d, want %0d", space, want.space));
      if (last !== want.last)
        report_mismatch($sformatf("is_last %0b, want %0b", last, want.last));
      if (elapsed !== want.elapsed)
        report_mismatch($sformatf("elapsed_us %0d, want %0d", elapsed, want.elapsed));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       command_code = '0;
  logic                   ends_keypress = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [TIME_W-1:0]      mark_us;
  logic [TIME_W-1:0]      space_us;
  logic                   is_last;
  logic [ELAPSED_W-1:0]   elapsed_us;

  frame_scoreboard board;
  pace_t           pace = PACE_NONE;
  int unsigned     quiet_cycles = 0;

  ir_dibit_frame_encoder #(
    .MARK_US (MARK_US_DEFAULT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command_code  (command_code),
    .ends_keypress (ends_keypress),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mark_us       (mark_us),
    .space_us      (space_us),
    .is_last       (is_last),
    .elapsed_us    (elapsed_us)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check each word taken, then pick the next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_word(mark_us, space_us, is_last, elapsed_us);
    if (pace == PACE_RECEIVER)
      out_ready <= ($urandom_range(99) >= 68);
    else if (pace == PACE_BOTH)
      out_ready <= ($urandom_range(99) >= 16);
    else
      out_ready <= 1'b1;
  end

  // Give up once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Write one register; drop valid after the last of a batch
  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task write_all(logic [CFG_DATA_W-1:0] data);
    int i;
    for (i = REG_ADDRESS; i <= REG_SPACE_THREE; i++)
      write_reg(i[CFG_INDEX_W-1:0], data, i == REG_SPACE_THREE);
  endtask

  // Offer one frame request, hold it until taken, then idle as the pace asks
  task send_request(logic [CMD_W-1:0] cmd, logic ends);
    int unsigned gap;
    int unsigned idle_pct;
    in_valid      <= 1'b1;
    command_code  <= cmd;
    ends_keypress <= ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(cmd, ends);
    idle_pct = (pace == PACE_SENDER) ? 68 : (pace == PACE_BOTH) ? 16 : 0;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and hold until every pending word has come out
  task wait_drained();
    while (board.pending.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int ph;
    int k;
    int i;
    int unsigned pick;
    logic [CFG_DATA_W-1:0] value;

    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timing; toggle flips after the first, third and fourth frames
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b0);
    send_request(8'h55, 1'b1);
    send_request(8'hAA, 1'b1);
    send_request(8'h0F, 1'b0);
    wait_drained();

    // All registers at zero
    write_all('0);
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b0);
    wait_drained();

    // Unknown indexes ignored, then all ones with excess bits dropped
    write_reg(REG_NONE_LOW, 16'h1234, 1'b0);
    write_reg(REG_NONE_TOP, '0, 1'b0);
    write_all('1);
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b1);
    send_request(8'h5A, 1'b0);
    wait_drained();

    // Distinct values on every register
    write_reg(REG_ADDRESS,      16'hC35A, 1'b0);
    write_reg(REG_EXTRA,        16'h0055, 1'b0);
    write_reg(REG_HEADER_MARK,  16'd9,    1'b0);
    write_reg(REG_HEADER_SPACE, 16'd4095, 1'b0);
    write_reg(REG_SPACE_ZERO,   16'd1,    1'b0);
    write_reg(REG_SPACE_ONE,    16'd100,  1'b0);
    write_reg(REG_SPACE_TWO,    16'd2000, 1'b0);
    write_reg(REG_SPACE_THREE,  16'd4094, 1'b1);
    send_request(8'h3C, 1'b1);
    send_request(8'hC3, 1'b0);
    wait_drained();

    // Random settings, each phase under one pace
    for (ph = 0; ph < 8; ph++) begin
      pace = PACE_NONE;
      write_reg(CFG_INDEX_W'($urandom_range(REG_NONE_TOP, REG_NONE_LOW)),
                CFG_DATA_W'($urandom_range(16'hFFFF)), 1'b0);
      for (i = REG_ADDRESS; i <= REG_SPACE_THREE; i++) begin
        pick = $urandom_range(3);
        value = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_DATA_W'($urandom_range(16'hFFFF));
        write_reg(i[CFG_INDEX_W-1:0], value, i == REG_SPACE_THREE);
      end
      pace = pace_t'(ph % 4);
      for (k = 0; k < 40; k++) begin
        if (k == 20 && pace == PACE_SENDER) wait_drained();
        send_request(CMD_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
